// ===== rtl/cmi_pkg.sv =====
// Shared widths, payload types and constants of the colormap gradient interpolator.
package cmi_pkg;

    localparam int IDX_W       = 8;
    localparam int LEN_W       = 9;
    localparam int CHAN_W      = 8;
    localparam int CHAN_COUNT  = 3;
    localparam int STOP_COUNT  = 4;
    localparam int SEG_W       = $clog2(STOP_COUNT);
    localparam int FRAC_BITS   = 16;
    localparam int POS_W       = SEG_W + FRAC_BITS;
    localparam int MAX_ENTRIES = 256;
    localparam int DIV_W       = $clog2(MAX_ENTRIES);
    localparam int NUM_W       = IDX_W + 2;
    localparam int DIV_STAGES  = 6;
    localparam int BITS_PER_STAGE = POS_W / DIV_STAGES;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = CHAN_COUNT * CHAN_W;

    typedef logic [CHAN_COUNT-1:0][CHAN_W-1:0] color_t;
    typedef color_t [STOP_COUNT-1:0] stops_t;

    // One transaction inside the divider: partial remainder plus a shift
    // register that feeds numerator bits in and quotient bits out.
    typedef struct packed {
        logic             err;
        logic [DIV_W-1:0] divisor;
        logic [DIV_W-1:0] rem;
        logic [POS_W-1:0] work;
    } div_tok_t;

    // Gradient position, integer stop in the top bits.
    typedef struct packed {
        logic             err;
        logic [POS_W-1:0] pos;
    } pos_tok_t;

endpackage

// ===== rtl/cmi_divider.sv =====
// Pipelined restoring divider: position = index*3*2^16 / (length-1).
module cmi_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cmi_pkg::div_tok_t in_tok,
    output logic              out_valid,
    input  logic              out_ready,
    output cmi_pkg::pos_tok_t out_pos
);
    import cmi_pkg::*;

    logic [DIV_STAGES-1:0] v_reg;
    logic [DIV_STAGES-1:0] v_next;
    logic [DIV_STAGES:0]   stage_ready;
    div_tok_t              tok_reg  [DIV_STAGES];
    div_tok_t              tok_next [DIV_STAGES];

    // A few quotient bits per stage.
    function automatic div_tok_t div_step(div_tok_t t);
        div_tok_t       r;
        logic [DIV_W:0] trial;
        r = t;
        for (int b = 0; b < BITS_PER_STAGE; b++)
        begin
            trial = {r.rem, r.work[POS_W-1]};
            if (trial >= {1'b0, r.divisor})
            begin
                r.rem  = DIV_W'(trial - {1'b0, r.divisor});
                r.work = {r.work[POS_W-2:0], 1'b1};
            end
            else
            begin
                r.rem  = trial[DIV_W-1:0];
                r.work = {r.work[POS_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    // A stage loads when it is empty or its content moves on.
    always_comb
    begin
        stage_ready[DIV_STAGES] = out_ready;
        for (int k = DIV_STAGES - 1; k >= 0; k--)
        begin
            stage_ready[k] = !v_reg[k] || stage_ready[k+1];
        end
    end

    assign v_next = {v_reg[DIV_STAGES-2:0], in_valid};

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            if (k == 0)
            begin : g_first
                assign tok_next[k] = div_step(in_tok);
            end
            else
            begin : g_rest
                assign tok_next[k] = div_step(tok_reg[k-1]);
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[k])
                begin
                    tok_reg[k] <= tok_next[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                if (stage_ready[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    assign in_ready    = stage_ready[0];
    assign out_valid   = v_reg[DIV_STAGES-1];
    assign out_pos.err = tok_reg[DIV_STAGES-1].err;
    assign out_pos.pos = tok_reg[DIV_STAGES-1].work;

endmodule

// ===== rtl/cmi_blend.sv =====
// Stop selection, per-channel linear blend with rounding, output register.
module cmi_blend (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cmi_pkg::pos_tok_t in_tok,
    input  cmi_pkg::stops_t   stops,
    output logic              out_valid,
    input  logic              out_ready,
    output cmi_pkg::color_t   out_color,
    output logic              out_err
);
    import cmi_pkg::*;

    localparam int DIFF_W = CHAN_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
    localparam int ACC_W  = PROD_W;

    typedef struct packed {
        logic                                err;
        logic [FRAC_BITS-1:0]                frac;
        color_t                              lo;
        logic [CHAN_COUNT-1:0][DIFF_W-1:0]   diff;
    } sel_tok_t;

    typedef struct packed {
        logic                                err;
        color_t                              lo;
        logic [CHAN_COUNT-1:0][PROD_W-1:0]   prod;
    } prod_tok_t;

    typedef struct packed {
        logic   err;
        color_t color;
    } res_tok_t;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

    logic      sel_v_reg, prod_v_reg, out_v_reg;
    logic      sel_rdy, prod_rdy, out_rdy;
    sel_tok_t  sel_reg, sel_next;
    prod_tok_t prod_reg, prod_next;
    res_tok_t  out_reg, out_next;

    logic [SEG_W-1:0]        seg;
    logic                    last_seg;
    color_t                  lo_stop, hi_stop;
    logic signed [PROD_W-1:0] mul_a [CHAN_COUNT];
    logic signed [PROD_W-1:0] mul_b [CHAN_COUNT];
    logic signed [ACC_W-1:0]  acc   [CHAN_COUNT];

    assign out_rdy  = !out_v_reg  || out_ready;
    assign prod_rdy = !prod_v_reg || out_rdy;
    assign sel_rdy  = !sel_v_reg  || prod_rdy;
    assign in_ready = sel_rdy;

    // Select the stop pair; the top stop blends with itself at weight zero.
    always_comb
    begin
        seg      = in_tok.pos[POS_W-1:FRAC_BITS];
        last_seg = (seg == SEG_W'(STOP_COUNT - 1));
        lo_stop  = stops[seg];
        hi_stop  = last_seg ? lo_stop : stops[seg + SEG_W'(1)];
        sel_next.err  = in_tok.err;
        sel_next.frac = last_seg ? '0 : in_tok.pos[FRAC_BITS-1:0];
        sel_next.lo   = lo_stop;
        for (int c = 0; c < CHAN_COUNT; c++)
        begin
            sel_next.diff[c] = {1'b0, hi_stop[c]} - {1'b0, lo_stop[c]};
        end
    end

    // (hi - lo) * frac, signed.
    always_comb
    begin
        prod_next.err = sel_reg.err;
        prod_next.lo  = sel_reg.lo;
        for (int c = 0; c < CHAN_COUNT; c++)
        begin
            mul_a[c] = PROD_W'($signed(sel_reg.diff[c]));
            mul_b[c] = $signed({{(PROD_W - FRAC_BITS){1'b0}}, sel_reg.frac});
            prod_next.prod[c] = mul_a[c] * mul_b[c];
        end
    end

    // lo*2^16 + product + half, keep the integer byte; black on a range error.
    always_comb
    begin
        out_next.err = prod_reg.err;
        for (int c = 0; c < CHAN_COUNT; c++)
        begin
            acc[c] = $signed({{(ACC_W - CHAN_W - FRAC_BITS){1'b0}}, prod_reg.lo[c],
                              {FRAC_BITS{1'b0}}})
                     + $signed(prod_reg.prod[c]) + ROUND_HALF;
            out_next.color[c] = prod_reg.err ? '0 : acc[c][FRAC_BITS +: CHAN_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (sel_rdy)
            begin
                sel_v_reg <= in_valid;
            end
            if (prod_rdy)
            begin
                prod_v_reg <= sel_v_reg;
            end
            if (out_rdy)
            begin
                out_v_reg <= prod_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel_rdy)
        begin
            sel_reg <= sel_next;
        end
        if (prod_rdy)
        begin
            prod_reg <= prod_next;
        end
        if (out_rdy)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_v_reg;
    assign out_color = out_reg.color;
    assign out_err   = out_reg.err;

endmodule

// ===== rtl/gradient_colormap_interpolator.sv =====
// Top level of the colormap gradient interpolator: registers, front stage, pipeline.
//
// Returns the RGB color of one colormap entry on a gradient through four
// configurable color stops. Entry i of an L-entry map sits at position
// i*3/(L-1) (16 fractional bits, truncated); the integer part picks the stop
// pair and the fraction blends each channel, rounded half up to 8 bits.
// An index at or above L, or L below 2, gives range_error with black. L
// above 256 is taken as 256. One transaction is accepted per clock while the
// output is not stalled; each result passes through one front stage, six
// divider stages of three quotient bits each, and three blend stages (select,
// multiply, round). Every stage holds its own valid bit and loads whenever it
// is empty or its content moves on, so bubbles close up and a stalled output
// only backs up the pipeline once it is full. Configuration writes take effect
// at once and are meant to be made with no transaction in flight.
module gradient_colormap_interpolator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [cmi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cmi_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [cmi_pkg::IDX_W-1:0]       entry_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [cmi_pkg::CHAN_W-1:0]      red,
    output logic [cmi_pkg::CHAN_W-1:0]      green,
    output logic [cmi_pkg::CHAN_W-1:0]      blue,
    output logic                            range_error
);
    import cmi_pkg::*;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAP_LENGTH = 3'd0,
        REG_STOP_ZERO  = 3'd1,
        REG_STOP_ONE   = 3'd2,
        REG_STOP_TWO   = 3'd3,
        REG_STOP_THREE = 3'd4
    } cfg_reg_t;

    localparam logic [LEN_W-1:0]  LEN_RESET   = LEN_W'(256);
    localparam logic [LEN_W-1:0]  LEN_MAX     = LEN_W'(MAX_ENTRIES);
    localparam logic [LEN_W-1:0]  LEN_MIN     = LEN_W'(2);
    localparam color_t            STOP0_RESET = 24'hFF0000;
    localparam color_t            STOP1_RESET = 24'hFFFF00;
    localparam color_t            STOP2_RESET = 24'h00FFFF;
    localparam color_t            STOP3_RESET = 24'h0000FF;

    // Configuration registers.
    logic [LEN_W-1:0] map_length_reg;
    stops_t           stops_reg;

    // Front stage.
    logic             front_v_reg;
    div_tok_t         front_reg, front_next;
    logic             front_rdy;
    logic [LEN_W-1:0] len_sat;
    logic [NUM_W-1:0] num;

    // Divider to blend.
    logic     div_in_ready;
    logic     div_out_valid;
    logic     blend_in_ready;
    pos_tok_t div_pos;
    color_t   color;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_length_reg <= LEN_RESET;
            stops_reg[0]   <= STOP0_RESET;
            stops_reg[1]   <= STOP1_RESET;
            stops_reg[2]   <= STOP2_RESET;
            stops_reg[3]   <= STOP3_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MAP_LENGTH: map_length_reg <= cfg_data[LEN_W-1:0];
                REG_STOP_ZERO:  stops_reg[0]   <= color_t'(cfg_data);
                REG_STOP_ONE:   stops_reg[1]   <= color_t'(cfg_data);
                REG_STOP_TWO:   stops_reg[2]   <= color_t'(cfg_data);
                REG_STOP_THREE: stops_reg[3]   <= color_t'(cfg_data);
                default:        ;
            endcase
        end
    end

    // Range check and divider setup. The numerator is index*3 shifted up by
    // the fraction width; its bits above the quotient width seed the
    // remainder, which stays below the divisor whenever the index is valid.
    always_comb
    begin
        len_sat = (map_length_reg > LEN_MAX) ? LEN_MAX : map_length_reg;
        num     = NUM_W'({entry_index, 1'b0}) + NUM_W'(entry_index);
        front_next.err     = (len_sat < LEN_MIN) || (LEN_W'(entry_index) >= len_sat);
        front_next.divisor = DIV_W'(len_sat - LEN_W'(1));
        front_next.rem     = DIV_W'(num >> SEG_W);
        front_next.work    = {num[SEG_W-1:0], {FRAC_BITS{1'b0}}};
    end

    assign front_rdy = !front_v_reg || div_in_ready;
    assign in_ready  = front_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_v_reg <= 1'b0;
        end
        else if (front_rdy)
        begin
            front_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_rdy)
        begin
            front_reg <= front_next;
        end
    end

    cmi_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_v_reg),
        .in_ready  (div_in_ready),
        .in_tok    (front_reg),
        .out_valid (div_out_valid),
        .out_ready (blend_in_ready),
        .out_pos   (div_pos)
    );

    cmi_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_out_valid),
        .in_ready  (blend_in_ready),
        .in_tok    (div_pos),
        .stops     (stops_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_color (color),
        .out_err   (range_error)
    );

    assign red   = color[2];
    assign green = color[1];
    assign blue  = color[0];

endmodule

// ===== dv/gradient_colormap_interpolator_test.sv =====
// Self-checking testbench for the gradient colormap interpolator: directed and random lookups.
module gradient_colormap_interpolator_test;
    import cmi_pkg::*;

    // Register map of the configuration port. Indexes above the last stop are
    // unused and writes to them must leave the block untouched.
    typedef enum int {
        REG_MAP_LENGTH = 0,
        REG_STOP_ZERO  = 1,
        REG_STOP_ONE   = 2,
        REG_STOP_TWO   = 3,
        REG_STOP_THREE = 4
    } cfg_reg_t;

    localparam int          REG_COUNT   = REG_STOP_THREE + 1;
    localparam int unsigned FRAC_ONE    = 1 << FRAC_BITS;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD   = 200;
    localparam int unsigned DRAIN_WAIT  = 20;

    // One color lookup as it leaves the block.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              range_error;
    } color_result_t;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic [IDX_W-1:0]       entry_index  = '0;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    logic [CHAN_W-1:0]      red;
    logic [CHAN_W-1:0]      green;
    logic [CHAN_W-1:0]      blue;
    logic                   range_error;

    // Shadow copy of the configuration, starting from the reset values.
    logic [LEN_W-1:0]      model_length = 9'd256;
    logic [CFG_DATA_W-1:0] model_stops [STOP_COUNT] =
        '{24'hFF0000, 24'hFFFF00, 24'h00FFFF, 24'h0000FF};

    // Indexes still to be offered, and colors predicted for accepted lookups.
    logic [IDX_W-1:0] pending_indices [$];
    color_result_t    expected_colors [$];

    // Idle odds: a burst starts with probability 1/idle_odds; zero turns idling off.
    int unsigned idle_odds   = 0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;
    int unsigned hold_left   = 0;
    bit          hold_done   = 1'b0;
    int unsigned error_count = 0;

    gradient_colormap_interpolator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .entry_index  (entry_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .range_error  (range_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Linear blend of one channel, weight frac/65536 toward hi, halves rounded up.
    function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] lo,
                                                      input logic [CHAN_W-1:0] hi,
                                                      input int unsigned frac);
        logic [31:0] acc;
        acc = lo * (FRAC_ONE - frac) + hi * frac + FRAC_ONE / 2;
        return acc[FRAC_BITS +: CHAN_W];
    endfunction

    // Color of one colormap entry under the current shadow configuration.
    function automatic color_result_t gradient_color(input logic [IDX_W-1:0] idx);
        color_result_t         res;
        int unsigned           len;
        int unsigned           pos;
        int unsigned           seg;
        int unsigned           frac;
        logic [CFG_DATA_W-1:0] lo_stop;
        logic [CFG_DATA_W-1:0] hi_stop;
        res = '0;
        len = 32'(model_length);
        // Lengths past the table size saturate.
        if (len > MAX_ENTRIES)
            len = MAX_ENTRIES;
        // Short map or index past the end: flagged, black.
        if (len < 2 || idx >= len)
        begin
            res.range_error = 1'b1;
            return res;
        end
        pos  = (int'(idx) * (STOP_COUNT - 1) * FRAC_ONE) / (len - 1);
        seg  = pos >> FRAC_BITS;
        frac = pos & (FRAC_ONE - 1);
        // Last stop: no stop above, so no blend.
        if (seg >= STOP_COUNT - 1)
        begin
            seg  = STOP_COUNT - 1;
            frac = 0;
        end
        lo_stop   = model_stops[seg];
        hi_stop   = (seg + 1 < STOP_COUNT) ? model_stops[seg + 1] : lo_stop;
        res.red   = mix_channel(lo_stop[2*CHAN_W +: CHAN_W], hi_stop[2*CHAN_W +: CHAN_W], frac);
        res.green = mix_channel(lo_stop[CHAN_W +: CHAN_W], hi_stop[CHAN_W +: CHAN_W], frac);
        res.blue  = mix_channel(lo_stop[0 +: CHAN_W], hi_stop[0 +: CHAN_W], frac);
        return res;
    endfunction

    // Sender: offers queued indexes, holds each until accepted, and records the
    // predicted color of every accepted transaction.
    always @(posedge clk)
    begin : index_driver
        logic             next_valid;
        logic [IDX_W-1:0] next_index;
        next_valid = in_valid;
        next_index = entry_index;
        if (rst_n)
        begin
            // No idling at all while idling is switched off.
            if (idle_odds == 0)
                gap_left = 0;
            if (in_valid && in_ready)
            begin
                expected_colors.push_back(gradient_color(entry_index));
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_indices.size() > 0)
                begin
                    next_valid = 1'b1;
                    next_index = pending_indices.pop_front();
                    // gap counts down once this transaction has gone
                    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                        gap_left = $urandom_range(1, 10);
                end
            end
        end
        in_valid    <= next_valid;
        entry_index <= next_index;
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Receiver: checks every accepted result against the oldest prediction and
    // throttles out_ready with short stalls and one long hold.
    always @(posedge clk)
    begin : result_monitor
        color_result_t want;
        logic          next_ready;
        next_ready = out_ready;
        if (rst_n)
        begin
            if (idle_odds == 0)
                stall_left = 0;
            if (out_valid && out_ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    $error("result with no lookup outstanding: rgb %0d %0d %0d err %0d",
                           red, green, blue, range_error);
                    error_count++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    compare_field("red", int'(want.red), int'(red));
                    compare_field("green", int'(want.green), int'(green));
                    compare_field("blue", int'(want.blue), int'(blue));
                    compare_field("range_error", int'(want.range_error),
                                  int'(range_error));
                end
            end
            // Long hold while plenty is still queued: the pipeline fills up and
            // in_ready must drop without losing anything.
            if (!hold_done && idle_odds != 0 && pending_indices.size() > 40)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
                if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                    stall_left = $urandom_range(1, 10);
            end
        end
        out_ready <= next_ready;
    end

    // Register write; the shadow copy follows the same masking as the block.
    task automatic write_reg(input int reg_idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= reg_idx[CFG_INDEX_W-1:0];
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (reg_idx == REG_MAP_LENGTH)
            model_length = value[LEN_W-1:0];
        else if (reg_idx < REG_COUNT)
            model_stops[reg_idx - REG_STOP_ZERO] = value;
    endtask

    // Returns on a falling edge once nothing is queued, offered or in flight.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_indices.size() != 0 || in_valid || expected_colors.size() != 0);
    endtask

    task automatic queue_index(input int unsigned idx);
        logic [IDX_W-1:0] trimmed;
        trimmed = IDX_W'(idx);
        pending_indices.push_back(trimmed);
    endtask

    // Random setup: mostly ordinary lengths, sometimes short, saturated or tiny
    // maps; stops sometimes all black or all white. Unused indexes sometimes get noise.
    task automatic randomize_setup();
        int unsigned           pick;
        int unsigned           len;
        logic [CFG_DATA_W-1:0] word;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       len = $urandom_range(0, 1);
            1:       len = $urandom_range(MAX_ENTRIES + 1, (1 << LEN_W) - 1);
            2:       len = MAX_ENTRIES;
            3:       len = $urandom_range(2, 8);
            default: len = $urandom_range(2, MAX_ENTRIES);
        endcase
        word = CFG_DATA_W'($urandom);
        word[LEN_W-1:0] = LEN_W'(len);
        write_reg(REG_MAP_LENGTH, word);
        for (int r = REG_STOP_ZERO; r <= REG_STOP_THREE; r++)
        begin
            pick = $urandom_range(0, 7);
            if (pick == 0)
                word = '0;
            else if (pick == 1)
                word = '1;
            else
                word = CFG_DATA_W'($urandom);
            write_reg(r, word);
        end
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(REG_COUNT, (1 << CFG_INDEX_W) - 1),
                      CFG_DATA_W'($urandom));
    endtask

    // Mostly in-range entries, with the last entry, the first one past the end
    // (wraps to zero for a full map) and fully random indexes mixed in.
    task automatic queue_random_indices(input int unsigned count);
        int unsigned eff_len;
        int unsigned pick;
        eff_len = (model_length > MAX_ENTRIES) ? MAX_ENTRIES : 32'(model_length);
        repeat (count)
        begin
            pick = $urandom_range(0, 9);
            if (eff_len >= 2 && pick < 6)
                queue_index($urandom_range(0, eff_len - 1));
            else if (eff_len >= 2 && pick == 6)
                queue_index(eff_len - 1);
            else if (pick == 7)
                queue_index(eff_len);
            else
                queue_index($urandom_range(0, (1 << IDX_W) - 1));
        end
    endtask

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        idle_odds = 3;

        // Reset configuration: ends of the map and exact stop positions.
        @(negedge clk);
        foreach (model_stops[s])
            queue_index(s * 85);
        queue_index(1);
        queue_index(128);
        queue_index(254);
        wait_until_drained();

        // Four-entry map, one entry per stop, extreme colors. The length word
        // carries junk above bit 8 that the register must drop.
        write_reg(REG_MAP_LENGTH, 24'hFFFE04);
        write_reg(REG_STOP_ZERO, 24'h000000);
        write_reg(REG_STOP_ONE, 24'hFFFFFF);
        write_reg(REG_STOP_TWO, 24'h00FF00);
        write_reg(REG_STOP_THREE, 24'hFF00FF);
        @(negedge clk);
        for (int i = 0; i <= 4; i++)
            queue_index(i);
        queue_index(255);
        wait_until_drained();

        // Smallest legal map: second entry lands on the last stop.
        write_reg(REG_MAP_LENGTH, CFG_DATA_W'(2));
        @(negedge clk);
        for (int i = 0; i <= 2; i++)
            queue_index(i);
        wait_until_drained();

        // Short maps flag every lookup.
        write_reg(REG_MAP_LENGTH, CFG_DATA_W'(1));
        @(negedge clk);
        queue_index(0);
        wait_until_drained();
        write_reg(REG_MAP_LENGTH, CFG_DATA_W'(0));
        @(negedge clk);
        queue_index(0);
        queue_index(255);
        wait_until_drained();

        // Oversized lengths saturate to a full table.
        write_reg(REG_MAP_LENGTH, CFG_DATA_W'((1 << LEN_W) - 1));
        @(negedge clk);
        queue_index(255);
        queue_index(0);
        queue_index(128);
        wait_until_drained();

        // Unused register indexes must not disturb the stops.
        write_reg(REG_MAP_LENGTH, CFG_DATA_W'(MAX_ENTRIES + 1));
        for (int r = REG_COUNT; r < (1 << CFG_INDEX_W); r++)
            write_reg(r, (r % 2) ? '1 : '0);
        @(negedge clk);
        queue_index(255);
        queue_index(100);
        wait_until_drained();

        // Random phases with varying idle intensity.
        for (int phase = 0; phase < 7; phase++)
        begin
            randomize_setup();
            @(negedge clk);
            idle_odds = (phase % 4 == 3) ? 0 : 2 + 2 * (phase % 4);
            queue_random_indices(110);
            wait_until_drained();
        end

        // Closing phase at full throughput on both sides.
        randomize_setup();
        @(negedge clk);
        idle_odds = 0;
        queue_random_indices(80);
        wait_until_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("gradient_colormap_interpolator test passed");
        else
            $display("gradient_colormap_interpolator test failed");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("gradient_colormap_interpolator test failed");
        $finish;
    end

endmodule

// ===== gradient_colormap_interpolator.f =====
rtl/cmi_pkg.sv
rtl/cmi_divider.sv
rtl/cmi_blend.sv
rtl/gradient_colormap_interpolator.sv
dv/gradient_colormap_interpolator_test.sv
